[design/assert_macros.svh]
// Assertion macros shared by the allocator RTL.
// Each macro expects signals named clock and reset in the including module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The condition holds at every clock edge outside reset.
`define ASSERT_ALWAYS(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) \
      else $error(msg);

// The consequent holds in the same cycle as the antecedent.
`define ASSERT_IMPLIES(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[design/bfba_pkg.sv]
// Package for the best-fit block allocator: field widths, codes and shared types.
// Used by bfba_scan_unit and best_fit_block_allocator_top; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package bfba_pkg;

   localparam int NUM_BLOCKS_DEFAULT = 32;

   localparam int SIZE_W   = 16;
   localparam int STATUS_W = 2;
   localparam int INDEX_W  = 5;

   // Request kinds carried on the input side.
   localparam logic ACT_LOAD  = 1'b0;
   localparam logic ACT_ALLOC = 1'b1;

   // Result codes.
   localparam logic [STATUS_W-1:0] STATUS_LOADED   = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_REJECTED = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_ALLOC    = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_NO_FIT   = 2'd3;

   // Control from the sequencer to the scan unit.
   typedef struct packed {
      logic clear;   // start of a new search
      logic sample;  // a table entry is presented this cycle
      logic used;    // that entry is already allocated
   } scan_ctl_type;

endpackage

`default_nettype wire

[design/bfba_scan_unit.sv]
// Shared subtract-and-compare unit that keeps the best fit seen so far.
// Depends on bfba_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module bfba_scan_unit #(
   parameter int NUM_BLOCKS = bfba_pkg::NUM_BLOCKS_DEFAULT,
   parameter int IDX_W      = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1
) (
   input  wire                           clock,
   input  wire                           reset,
   input  wire  bfba_pkg::scan_ctl_type  ctl,
   input  wire  [IDX_W-1:0]              sample_idx,
   input  wire  [bfba_pkg::SIZE_W-1:0]   sample_size,
   input  wire  [bfba_pkg::SIZE_W-1:0]   req_size,
   output logic                          found,
   output logic [IDX_W-1:0]              best_idx,
   output logic [bfba_pkg::SIZE_W-1:0]   best_size,
   output logic [bfba_pkg::SIZE_W-1:0]   best_left
);
   import bfba_pkg::*;

   logic              found_ff, found_in;
   logic [IDX_W-1:0]  best_idx_ff;
   logic [SIZE_W-1:0] best_size_ff;
   logic [SIZE_W-1:0] best_left_ff;
   logic [SIZE_W:0]   diff;
   logic              better;

   // A borrow out of the subtraction means the block is too small. Entries are
   // presented in ascending order, so a strict compare keeps the lowest index
   // on a tie.
   always_comb begin
      diff   = {1'b0, sample_size} - {1'b0, req_size};
      better = ctl.sample && !ctl.used && !diff[SIZE_W] &&
               (!found_ff || (diff[SIZE_W-1:0] < best_left_ff));
      found_in = ctl.clear ? 1'b0 : (found_ff || better);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         found_ff <= 1'b0;
      end else begin
         found_ff <= found_in;
      end
   end

   always_ff @(posedge clock) begin
      if (better && !ctl.clear) begin
         best_idx_ff  <= sample_idx;
         best_size_ff <= sample_size;
         best_left_ff <= diff[SIZE_W-1:0];
      end
   end

   assign found     = found_ff;
   assign best_idx  = best_idx_ff;
   assign best_size = best_size_ff;
   assign best_left = best_left_ff;

   `ASSERT_IMPLIES(a_best_consistent, found_ff,
      (best_size_ff >= req_size) && (best_left_ff == best_size_ff - req_size),
      "best fit leftover does not match its size")
   `ASSERT_NEXT(a_clear_forgets, ctl.clear, !found_ff,
      "search start did not drop the previous best")

endmodule

`default_nettype wire

[design/best_fit_block_allocator_top.sv]
// Top level of the best-fit block allocator: sequencer, size table and result register.
// Depends on bfba_pkg, bfba_scan_unit and assert_macros.svh.
//
//   channel   direction  tdata                       tuser
//   req_      in         size_value[15:0]            action
//   rsp_      out        block_index, size, leftover status[1:0]
//
// A load is taken in its transfer cycle and committed in the finish state once the result register is free.
// A request scans the loaded entries before its result is registered: the
// scan reads one table entry per cycle from the single read port of the size
// memory, and each entry is compared by the one shared subtract-and-compare
// unit. The block takes a new transfer as soon as the result is registered,
// even while that result still waits on rsp_tready.
// Reset clears the load count and every in-use bit; the size table is not
// cleared, since only loaded entries are ever read.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module best_fit_block_allocator_top #(
   parameter int NUM_BLOCKS = bfba_pkg::NUM_BLOCKS_DEFAULT
) (
   input  wire         clock,
   input  wire         reset,
   // Input channel.
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire  [15:0] req_tdata,   // [15:0] size_value
   input  wire         req_tuser,   // [0] action: load or allocate
   // Result channel.
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [39:0] rsp_tdata,   // [4:0] block_index, [20:5] block_size,
                                    // [36:21] leftover, [39:37] zero
   output logic [1:0]  rsp_tuser    // [1:0] status
);
   import bfba_pkg::*;

   localparam int IDX_W = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
   localparam int CNT_W = $clog2(NUM_BLOCKS + 1);

   // Sequencer states.
   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_SCAN   = 2'd1;
   localparam logic [1:0] ST_FINISH = 2'd2;

   logic [1:0]            state_ff, state_in;
   logic                  action_ff;
   logic [SIZE_W-1:0]     value_ff;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic [CNT_W-1:0]      loaded_ff, loaded_in;
   logic [NUM_BLOCKS-1:0] in_use_ff, in_use_in;

   // Size table and its registered read port.
   logic [SIZE_W-1:0]     size_mem [NUM_BLOCKS];
   logic                  mem_we;
   logic [IDX_W-1:0]      mem_waddr;
   logic                  rd_issue;
   logic                  rd_valid_ff;
   logic                  rd_used_ff;
   logic [IDX_W-1:0]      rd_idx_ff;
   logic [SIZE_W-1:0]     rd_size_ff;

   // Result register.
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  rsp_load;
   logic [STATUS_W-1:0]   rsp_status_ff, rsp_status_in;
   logic [INDEX_W-1:0]    rsp_index_ff, rsp_index_in;
   logic [SIZE_W-1:0]     rsp_size_ff, rsp_size_in;
   logic [SIZE_W-1:0]     rsp_left_ff, rsp_left_in;

   scan_ctl_type          scan_ctl;
   logic                  best_found;
   logic [IDX_W-1:0]      best_idx;
   logic [SIZE_W-1:0]     best_size;
   logic [SIZE_W-1:0]     best_left;
   logic                  table_full;
   logic                  out_free;

   assign req_tready = (state_ff == ST_IDLE);
   assign table_full = (loaded_ff == CNT_W'(NUM_BLOCKS));
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign rd_issue   = (state_ff == ST_SCAN) && (cnt_ff < loaded_ff);

   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      loaded_in     = loaded_ff;
      in_use_in     = in_use_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_load      = 1'b0;
      rsp_status_in = STATUS_NO_FIT;
      rsp_index_in  = '0;
      rsp_size_in   = '0;
      rsp_left_in   = '0;
      mem_we        = 1'b0;
      mem_waddr     = loaded_ff[IDX_W-1:0];
      scan_ctl      = '{clear: 1'b0, sample: rd_valid_ff, used: rd_used_ff};

      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               scan_ctl.clear = 1'b1;
               cnt_in         = '0;
               state_in       = (req_tuser == ACT_ALLOC) ? ST_SCAN : ST_FINISH;
            end
         end
         ST_SCAN: begin
            // The last entry read is compared in the cycle the scan ends.
            if (rd_issue) begin
               cnt_in = cnt_ff + CNT_W'(1);
            end else begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_load     = 1'b1;
               state_in     = ST_IDLE;
               if (action_ff == ACT_LOAD) begin
                  if (table_full) begin
                     rsp_status_in = STATUS_REJECTED;
                  end else begin
                     mem_we                            = 1'b1;
                     in_use_in[loaded_ff[IDX_W-1:0]] = 1'b0;
                     rsp_status_in                     = STATUS_LOADED;
                     rsp_index_in                      = INDEX_W'(loaded_ff);
                     loaded_in                         = loaded_ff + CNT_W'(1);
                  end
               end else if (best_found) begin
                  in_use_in[best_idx] = 1'b1;
                  rsp_status_in       = STATUS_ALLOC;
                  rsp_index_in        = INDEX_W'(best_idx);
                  rsp_size_in         = best_size;
                  rsp_left_in         = best_left;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         loaded_ff    <= '0;
         in_use_ff    <= '0;
         rd_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         loaded_ff    <= loaded_in;
         in_use_ff    <= in_use_in;
         rd_valid_ff  <= rd_issue;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Request payload is captured on its transfer.
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         action_ff <= req_tuser;
         value_ff  <= req_tdata;
      end
   end

   // Size table: one write port for loads, one registered read port for the scan.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         size_mem[mem_waddr] <= value_ff;
      end
      if (rd_issue) begin
         rd_size_ff <= size_mem[cnt_ff[IDX_W-1:0]];
         rd_used_ff <= in_use_ff[cnt_ff[IDX_W-1:0]];
         rd_idx_ff  <= cnt_ff[IDX_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_status_ff <= rsp_status_in;
         rsp_index_ff  <= rsp_index_in;
         rsp_size_ff   <= rsp_size_in;
         rsp_left_ff   <= rsp_left_in;
      end
   end

   bfba_scan_unit #(
      .NUM_BLOCKS (NUM_BLOCKS),
      .IDX_W      (IDX_W)
   ) u_scan (
      .clock       (clock),
      .reset       (reset),
      .ctl         (scan_ctl),
      .sample_idx  (rd_idx_ff),
      .sample_size (rd_size_ff),
      .req_size    (value_ff),
      .found       (best_found),
      .best_idx    (best_idx),
      .best_size   (best_size),
      .best_left   (best_left)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = {3'b000, rsp_left_ff, rsp_size_ff, rsp_index_ff};

   `ASSERT_ALWAYS(a_loaded_bound, loaded_ff <= CNT_W'(NUM_BLOCKS), "load count beyond table depth")
   `ASSERT_IMPLIES(a_idle_no_read, req_tready, !rd_valid_ff, "table read pending while idle")
   `ASSERT_IMPLIES(a_scan_bound, state_ff == ST_SCAN, cnt_ff <= loaded_ff, "scan ran past the loaded entries")
   `ASSERT_NEXT(a_finish_result, (state_ff == ST_FINISH) && out_free, rsp_valid_ff && req_tready, "commit did not register a result")

endmodule

`default_nettype wire
